@@ rtl/core/ipa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipa_pkg
// Shared types and constants for the IPv4 address pool allocator.
// ----------------------------------------------------------------------------
package ipa_pkg;

  // Pool geometry
  localparam int unsigned POOL_BITS = 1024;
  localparam int unsigned MAP_BYTES = (POOL_BITS + 7) / 8;
  localparam int unsigned BYTE_AW   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int unsigned BYTE_CW   = $clog2(MAP_BYTES + 1);
  localparam int unsigned SIZE_W    = $clog2(POOL_BITS + 1);

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [7:0]        BYTE_FULL  = 8'hff;
  localparam logic [ADDR_W-1:0] MASK_RESET = 32'hffff_ff00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NETWORK_ADDRESS = 1'b0,
    CFG_SUBNET_MASK     = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    KIND_ALLOCATE = 1'b0,
    KIND_RELEASE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_ALLOCATED    = 2'd0,
    STATUS_DEPLETED     = 2'd1,
    STATUS_RELEASED     = 2'd2,
    STATUS_OUT_OF_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN_PRIME,
    ST_SCAN,
    ST_REL_CHECK,
    ST_REL_WRITE,
    ST_DONE
  } state_e;

  // Bitmap access request from the sequencer
  typedef struct packed {
    logic               rd_en;
    logic [BYTE_AW-1:0] rd_addr;
    logic               wr_en;
    logic [BYTE_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
  } map_req_t;

endpackage

@@ rtl/core/ip_address_pool_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_pool_allocator
// Bitmap first-fit allocator of IPv4 host addresses within a subnet.
// ----------------------------------------------------------------------------
// Usage:
//  - Config channel (cfg_valid_i/cfg_ready_o): index 0 network address,
//    index 1 netmask. Always ready; write only while no request is in flight.
//  - Request channel (in_valid_i/in_stall_o): one beat is an allocate or a
//    release. One request is worked on at a time; in_stall_o stays high
//    until the sequencer is back in idle.
//  - Response channel (out_valid_o/out_stall_i): one beat per request,
//    held in an output register. While the receiver stalls, the next request
//    can still be taken and worked on; its result waits until the output
//    register frees up.
//  - Steps from request beat to response beat: a release goes through PREP,
//    REL_CHECK, REL_WRITE if in range, and DONE; an allocate goes through
//    PREP, SCAN_PRIME, SCAN over N bytes, and DONE, where N is the number
//    of bytes scanned (0 for a pool of fewer than 8 addresses, up to
//    pool_bits/8 = 128). The bitmap memory port, one byte read per cycle,
//    sets the scan rate.
//  - Next request: the next request beat can be taken once the sequencer
//    is back in idle, in the cycle after the response is loaded.
//  - Reset: registers go to their reset values and the bitmap is swept to
//    zero, one byte per cycle, with in_stall_o high meanwhile.
// ----------------------------------------------------------------------------
module ip_address_pool_allocator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ipa_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ipa_pkg::ADDR_W-1:0]            cfg_data_i,
  // request
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  in_kind_i,
  input  logic [ipa_pkg::ADDR_W-1:0]            in_release_address_i,
  // response
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [1:0]                            out_status_o,
  output logic [ipa_pkg::ADDR_W-1:0]            out_granted_address_o
);

  localparam int unsigned AW = ipa_pkg::ADDR_W;

  // lowest clear bit of a byte that is not full
  function automatic logic [2:0] low_clear(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd7;
    for (int k = 7; k >= 0; k--) begin
      if (!b[k]) pos = 3'(k);
    end
    return pos;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [AW-1:0] net_q, mask_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_q  <= '0;
      mask_q <= ipa_pkg::MASK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ipa_pkg::cfg_idx_e'(cfg_index_i))
        ipa_pkg::CFG_NETWORK_ADDRESS: net_q  <= cfg_data_i;
        ipa_pkg::CFG_SUBNET_MASK:     mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Bitmap
  // --------------------------------------------------------------------------
  ipa_pkg::map_req_t map_req;
  logic [7:0]        map_rd_data;
  logic              clr_busy;

  ipa_bitmap u_bitmap (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (map_req),
    .rd_data_o  (map_rd_data),
    .clr_busy_o (clr_busy)
  );

  // --------------------------------------------------------------------------
  // Sequencer state and working registers
  // --------------------------------------------------------------------------
  ipa_pkg::state_e             state_q, state_d;
  logic                        kind_q;
  logic [AW-1:0]               addr_q;
  logic [AW-1:0]               base_q;
  logic [ipa_pkg::SIZE_W-1:0]  size_q;
  logic [ipa_pkg::BYTE_CW-1:0] bytes_q;
  logic [ipa_pkg::BYTE_AW-1:0] idx_q;
  logic [2:0]                  bit_q;
  logic [1:0]                  res_status_q;
  logic [AW-1:0]               res_addr_q;

  logic                        out_valid_q;
  logic [1:0]                  out_status_q;
  logic [AW-1:0]               out_addr_q;

  logic                        in_fire, out_fire, out_free;
  logic                        byte_free, scan_last;
  logic [2:0]                  clear_pos;
  logic [AW-1:0]               rel_idx;
  logic                        rel_in_range;
  logic [AW-1:0]               host_cnt;
  logic [ipa_pkg::SIZE_W-1:0]  size_sat;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  assign host_cnt = ~mask_q;
  assign size_sat = (host_cnt > AW'(ipa_pkg::POOL_BITS)) ?
                    ipa_pkg::SIZE_W'(ipa_pkg::POOL_BITS) :
                    host_cnt[ipa_pkg::SIZE_W-1:0];

  assign byte_free = (map_rd_data != ipa_pkg::BYTE_FULL);
  assign clear_pos = low_clear(map_rd_data);
  assign scan_last = ((ipa_pkg::BYTE_CW'(idx_q) + 1'b1) == bytes_q);

  assign rel_idx      = addr_q - base_q;
  assign rel_in_range = (rel_idx < AW'(size_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ipa_pkg::ST_IDLE: begin
        if (in_fire) state_d = ipa_pkg::ST_PREP;
      end
      ipa_pkg::ST_PREP: begin
        state_d = (ipa_pkg::kind_e'(kind_q) == ipa_pkg::KIND_RELEASE) ?
                  ipa_pkg::ST_REL_CHECK : ipa_pkg::ST_SCAN_PRIME;
      end
      ipa_pkg::ST_SCAN_PRIME: begin
        state_d = (bytes_q == '0) ? ipa_pkg::ST_DONE : ipa_pkg::ST_SCAN;
      end
      ipa_pkg::ST_SCAN: begin
        if (byte_free || scan_last) state_d = ipa_pkg::ST_DONE;
      end
      ipa_pkg::ST_REL_CHECK: begin
        state_d = rel_in_range ? ipa_pkg::ST_REL_WRITE : ipa_pkg::ST_DONE;
      end
      ipa_pkg::ST_REL_WRITE: begin
        state_d = ipa_pkg::ST_DONE;
      end
      ipa_pkg::ST_DONE: begin
        if (out_free) state_d = ipa_pkg::ST_IDLE;
      end
      default: state_d = ipa_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    map_req    = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ipa_pkg::ST_IDLE: begin
        in_stall_o = clr_busy;
      end
      ipa_pkg::ST_SCAN_PRIME: begin
        map_req.rd_en   = 1'b1;
        map_req.rd_addr = '0;
      end
      ipa_pkg::ST_SCAN: begin
        if (byte_free) begin
          map_req.wr_en   = 1'b1;
          map_req.wr_addr = idx_q;
          map_req.wr_data = map_rd_data | (8'h01 << clear_pos);
        end else if (!scan_last) begin
          map_req.rd_en   = 1'b1;
          map_req.rd_addr = idx_q + 1'b1;
        end
      end
      ipa_pkg::ST_REL_CHECK: begin
        map_req.rd_en   = rel_in_range;
        map_req.rd_addr = rel_idx[ipa_pkg::BYTE_AW+2:3];
      end
      ipa_pkg::ST_REL_WRITE: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = idx_q;
        map_req.wr_data = map_rd_data & ~(8'h01 << bit_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ipa_pkg::ST_IDLE: begin
        if (in_fire) begin
          kind_q <= in_kind_i;
          addr_q <= in_release_address_i;
        end
      end
      ipa_pkg::ST_PREP: begin
        base_q     <= (net_q & mask_q) + 1'b1;
        size_q     <= size_sat;
        bytes_q    <= ipa_pkg::BYTE_CW'(size_sat >> 3);
        res_addr_q <= '0;
      end
      ipa_pkg::ST_SCAN_PRIME: begin
        idx_q        <= '0;
        res_status_q <= ipa_pkg::STATUS_DEPLETED;
      end
      ipa_pkg::ST_SCAN: begin
        if (byte_free) begin
          res_status_q <= ipa_pkg::STATUS_ALLOCATED;
          res_addr_q   <= base_q + AW'({idx_q, clear_pos});
        end else if (!scan_last) begin
          idx_q <= idx_q + 1'b1;
        end
      end
      ipa_pkg::ST_REL_CHECK: begin
        idx_q        <= rel_idx[ipa_pkg::BYTE_AW+2:3];
        bit_q        <= rel_idx[2:0];
        res_status_q <= rel_in_range ? ipa_pkg::STATUS_RELEASED
                                     : ipa_pkg::STATUS_OUT_OF_RANGE;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ipa_pkg::ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ipa_pkg::ST_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_status_o          = out_status_q;
  assign out_granted_address_o = out_addr_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_req_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> in_stall_o)
    else $error("request taken during bitmap clear");

  a_scan_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ipa_pkg::ST_SCAN |-> (ipa_pkg::BYTE_CW'(idx_q) < bytes_q))
    else $error("scan index beyond pool");

  a_done_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ipa_pkg::ST_DONE && out_free) |=> out_valid_q)
    else $error("finished result not presented");

  a_zero_unless_granted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ipa_pkg::STATUS_ALLOCATED) |-> (out_addr_q == '0))
    else $error("address driven on a non-grant response");

endmodule

@@ rtl/core/ipa_bitmap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipa_bitmap
// Usage bitmap memory: one byte per row, registered read, one write port,
// and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module ipa_bitmap (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipa_pkg::map_req_t req_i,
  output logic [7:0]        rd_data_o,
  output logic              clr_busy_o
);

  logic [7:0]                  mem [ipa_pkg::MAP_BYTES];
  logic [7:0]                  rd_data_q;
  logic                        clr_busy_q, clr_busy_d;
  logic [ipa_pkg::BYTE_AW-1:0] clr_addr_q, clr_addr_d;

  // sweep one row per cycle
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      if (clr_addr_q == ipa_pkg::BYTE_AW'(ipa_pkg::MAP_BYTES - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= 8'h00;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

endmodule
